// ----- sv/atw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atw_pkg
// Shared types and constants of the ANSI text terminal writer: screen geometry,
// character codes, register indexes, control state and parser command word.
// ----------------------------------------------------------------------------
package atw_pkg;

   // screen geometry
   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 30;
   localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = 12;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int GLYPH_W     = 7;
   localparam int POS_W       = 8;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 1'd1;

   localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd80;
   localparam logic [ROW_W-1:0] ROWS_RESET    = 5'd30;

   // character codes
   localparam logic [7:0] ASCII_ESC      = 8'h1B;
   localparam logic [7:0] ASCII_LF       = 8'h0A;
   localparam logic [7:0] ASCII_CR       = 8'h0D;
   localparam logic [7:0] ASCII_0        = 8'h30;
   localparam logic [7:0] ASCII_9        = 8'h39;
   localparam logic [7:0] ASCII_UPPER_A  = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z  = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z  = 8'h7A;
   localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
   localparam logic [7:0] ASCII_H        = 8'h48;
   localparam logic [7:0] ASCII_F_LOWER  = 8'h66;
   localparam logic [7:0] ASCII_J        = 8'h4A;
   localparam logic [7:0] GLYPH_FIRST    = 8'h20;
   localparam logic [7:0] GLYPH_LAST     = 8'd126;

   // request action codes
   localparam logic ACT_FEED = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // escape parser phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEQ   = 2'd1,
      PH_DIGIT = 2'd2,
      PH_INTRO = 2'd3
   } esc_phase_type;

   // main sequencer
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CLEAR,
      ST_POST,
      ST_SCROLL,
      ST_FINISH
   } state_type;

   // command word from the escape parser for the byte being fed
   typedef struct packed {
      logic             busy;
      logic             set_cursor;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             clear_screen;
   } esc_cmd_type;

endpackage
`default_nettype wire

// ----- sv/atw_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atw_req_if
// Request channel: one word is a terminal byte to feed or a screen cell read.
// ----------------------------------------------------------------------------
interface atw_req_if;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [7:0]                char_byte;
   logic [atw_pkg::ADDR_W-1:0] cell_address;

   modport source (output valid, action, char_byte, cell_address, input ready);
   modport sink   (input valid, action, char_byte, cell_address, output ready);
endinterface
`default_nettype wire

// ----- sv/atw_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atw_rsp_if
// Response channel: one word per request, cell value and cursor position.
// ----------------------------------------------------------------------------
interface atw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [atw_pkg::GLYPH_W-1:0] cell_value;
   logic [atw_pkg::COL_W-1:0]   cursor_column;
   logic [atw_pkg::ROW_W-1:0]   cursor_row;

   modport source (output valid, cell_value, cursor_column, cursor_row, input ready);
   modport sink   (input valid, cell_value, cursor_column, cursor_row, output ready);
endinterface
`default_nettype wire

// ----- sv/atw_esc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// atw_esc
// Escape sequence parser. Tracks ESC, the introducer and up to two decimal
// parameters, and decodes cursor position and clear screen at the final letter.
// ----------------------------------------------------------------------------
module atw_esc (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            byte_in,
   output atw_pkg::esc_cmd_type       cmd
);

   atw_pkg::esc_phase_type phase_ff, phase_in;
   logic [7:0]  intro_ff, intro_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;

   logic        is_digit;
   logic        is_letter;
   logic [3:0]  digit;
   logic [1:0]  count_next;
   atw_pkg::esc_phase_type cur_phase;

   // decimal accumulate, saturating at 16 bits
   function automatic logic [15:0] add_digit(input logic [15:0] acc,
                                             input logic [3:0] d);
      logic [19:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   assign is_digit  = (byte_in >= atw_pkg::ASCII_0) && (byte_in <= atw_pkg::ASCII_9);
   assign is_letter = ((byte_in >= atw_pkg::ASCII_UPPER_A) &&
                       (byte_in <= atw_pkg::ASCII_UPPER_Z)) ||
                      ((byte_in >= atw_pkg::ASCII_LOWER_A) &&
                       (byte_in <= atw_pkg::ASCII_LOWER_Z));
   assign digit      = byte_in[3:0];
   assign count_next = (count_ff == 2'd3) ? 2'd3 : count_ff + 2'd1;

   // parser next state and command decode
   always_comb begin
      phase_in  = phase_ff;
      intro_in  = intro_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      cur_phase = phase_ff;
      cmd.busy         = (phase_ff != atw_pkg::PH_IDLE);
      cmd.set_cursor   = 1'b0;
      cmd.clear_screen = 1'b0;
      cmd.row          = 8'(first_ff - 16'd1);
      cmd.col          = 8'(second_ff - 16'd1);

      if (phase_ff == atw_pkg::PH_IDLE) begin
         if (byte_in == atw_pkg::ASCII_ESC) begin
            phase_in = atw_pkg::PH_INTRO;
            intro_in = 8'd0;
            count_in = 2'd0;
         end
      end else begin
         // first byte after ESC is the introducer
         if (phase_ff == atw_pkg::PH_INTRO) begin
            intro_in  = byte_in;
            cur_phase = atw_pkg::PH_SEQ;
         end
         phase_in = cur_phase;
         if (is_letter) begin
            if (intro_in == atw_pkg::ASCII_LBRACKET) begin
               if ((byte_in == atw_pkg::ASCII_H) || (byte_in == atw_pkg::ASCII_F_LOWER)) begin
                  cmd.set_cursor = (count_ff == 2'd2);
               end else if (byte_in == atw_pkg::ASCII_J) begin
                  cmd.clear_screen = (count_ff == 2'd1) && (first_ff == 16'd2);
               end
            end
            phase_in = atw_pkg::PH_IDLE;
         end else if (cur_phase == atw_pkg::PH_SEQ) begin
            // start of a new parameter
            if (is_digit) begin
               count_in = count_next;
               if (count_next == 2'd1) begin
                  first_in = {12'b0, digit};
               end else if (count_next == 2'd2) begin
                  second_in = {12'b0, digit};
               end
               phase_in = atw_pkg::PH_DIGIT;
            end
         end else if (is_digit) begin
            if (count_ff == 2'd1) begin
               first_in = add_digit(first_ff, digit);
            end else if (count_ff == 2'd2) begin
               second_in = add_digit(second_ff, digit);
            end
         end else begin
            phase_in = atw_pkg::PH_SEQ;
         end
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= atw_pkg::PH_IDLE;
         intro_ff  <= 8'd0;
         count_ff  <= 2'd0;
         first_ff  <= 16'd0;
         second_ff <= 16'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         intro_ff  <= intro_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/ansi_text_terminal_writer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer_top
// Character terminal: screen memory, cursor, escape parser and cell readout.
// ----------------------------------------------------------------------------
// A word is accepted only while the sequencer is idle and every accepted word
// returns one response word. A fed byte goes through the execute, post and
// finish steps and a cell read through the execute, read and finish steps
// before the next acceptance; the finish step waits for the response register
// to be taken. The single-port-per-direction screen memory is walked one cell
// a cycle, so ESC[2J and a scroll each walk columns*rows cells. After reset a
// clearing pass writes all 2400 cells, one per cycle, and no word is accepted
// until it ends. The response register lets the next word be accepted while a
// response is still waiting to be taken.
module ansi_text_terminal_writer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   atw_req_if.sink                              req_if,
   atw_rsp_if.source                            rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [atw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [atw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = atw_pkg::ADDR_W;
   localparam int CW = atw_pkg::COL_W;
   localparam int RW = atw_pkg::ROW_W;
   localparam int GW = atw_pkg::GLYPH_W;
   localparam int PW = atw_pkg::POS_W;

   atw_pkg::state_type state_ff, state_in;

   // configuration
   logic [CW-1:0] cols_ff, cols_in;
   logic [RW-1:0] rows_ff, rows_in;
   logic [CW-1:0] cols_used;
   logic [RW-1:0] rows_used;
   logic [AW-1:0] area_total;
   logic [AW-1:0] area_copy;

   // captured request word
   logic          act_ff, act_in;
   logic [7:0]    byte_ff, byte_in;
   logic [AW-1:0] addr_ff, addr_in;

   // cursor and work registers
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [PW-1:0] pcol_ff, pcol_in;
   logic [PW-1:0] prow_ff, prow_in;
   logic [GW-1:0] cell_ff, cell_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [AW-1:0] idx_ff, idx_in;

   // delayed scroll write
   logic          scr_wr_ff, scr_wr_in;
   logic [AW-1:0] scr_waddr_ff, scr_waddr_in;
   logic          scr_copy_ff, scr_copy_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0] rsp_cell_ff, rsp_cell_in;
   logic [CW-1:0] rsp_col_ff, rsp_col_in;
   logic [RW-1:0] rsp_row_ff, rsp_row_in;

   // screen memory ports
   logic [GW-1:0] screen_mem [0:atw_pkg::CELL_COUNT-1];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [GW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [GW-1:0] rd_data_ff;

   logic                 accept;
   logic                 esc_step;
   atw_pkg::esc_cmd_type esc_cmd;
   logic [AW-1:0]        cursor_addr;
   logic                 is_glyph;
   logic                 is_newline;

   atw_esc u_esc (
      .clock   (clock),
      .reset   (reset),
      .step    (esc_step),
      .byte_in (byte_ff),
      .cmd     (esc_cmd)
   );

   // registers in use, clamped to the screen
   assign cols_used = (cols_ff == '0) ? CW'(1) :
                      (cols_ff > CW'(atw_pkg::MAX_COLUMNS)) ? CW'(atw_pkg::MAX_COLUMNS) : cols_ff;
   assign rows_used = (rows_ff == '0) ? RW'(1) :
                      (rows_ff > RW'(atw_pkg::MAX_ROWS)) ? RW'(atw_pkg::MAX_ROWS) : rows_ff;
   assign area_total = AW'(rows_used) * AW'(cols_used);
   assign area_copy  = area_total - AW'(cols_used);

   assign cursor_addr = AW'(cur_col_ff) + AW'(cur_row_ff) * AW'(cols_used);
   assign is_glyph    = (byte_ff >= atw_pkg::GLYPH_FIRST) && (byte_ff <= atw_pkg::GLYPH_LAST);
   assign is_newline  = (byte_ff == atw_pkg::ASCII_LF) || (byte_ff == atw_pkg::ASCII_CR);

   assign req_if.ready = (state_ff == atw_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign esc_step     = (state_ff == atw_pkg::ST_EXEC) && (act_ff == atw_pkg::ACT_FEED);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cell_value    = rsp_cell_ff;
   assign rsp_if.cursor_column = rsp_col_ff;
   assign rsp_if.cursor_row    = rsp_row_ff;

   // sequencer: next state, memory ports and work registers
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      byte_in      = byte_ff;
      addr_in      = addr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      pcol_in      = pcol_ff;
      prow_in      = prow_ff;
      cell_in      = cell_ff;
      rd_ok_in     = rd_ok_ff;
      idx_in       = idx_ff;
      scr_wr_in    = 1'b0;
      scr_waddr_in = idx_ff;
      scr_copy_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;

      // the delayed scroll write has the write port to itself
      mem_we    = scr_wr_ff;
      mem_waddr = scr_waddr_ff;
      mem_wdata = scr_copy_ff ? rd_data_ff : '0;
      mem_re    = 1'b0;
      mem_raddr = addr_ff;

      case (state_ff)
         atw_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            idx_in    = idx_ff + AW'(1);
            if (idx_ff == AW'(atw_pkg::CELL_COUNT - 1)) begin
               idx_in   = '0;
               state_in = atw_pkg::ST_IDLE;
            end
         end

         atw_pkg::ST_IDLE: begin
            if (accept) begin
               act_in   = req_if.action;
               byte_in  = req_if.char_byte;
               addr_in  = req_if.cell_address;
               state_in = atw_pkg::ST_EXEC;
            end
         end

         atw_pkg::ST_EXEC: begin
            cell_in = '0;
            pcol_in = PW'(cur_col_ff);
            prow_in = PW'(cur_row_ff);
            if (act_ff == atw_pkg::ACT_READ) begin
               rd_ok_in = (addr_ff < AW'(atw_pkg::CELL_COUNT));
               mem_re   = (addr_ff < AW'(atw_pkg::CELL_COUNT));
               state_in = atw_pkg::ST_READ;
            end else begin
               state_in = atw_pkg::ST_POST;
               if (esc_cmd.busy) begin
                  if (esc_cmd.set_cursor) begin
                     pcol_in = esc_cmd.col;
                     prow_in = esc_cmd.row;
                  end
                  if (esc_cmd.clear_screen) begin
                     idx_in   = '0;
                     state_in = atw_pkg::ST_CLEAR;
                  end
               end else if (is_glyph) begin
                  mem_we    = 1'b1;
                  mem_waddr = cursor_addr;
                  mem_wdata = GW'(byte_ff - atw_pkg::GLYPH_FIRST);
                  pcol_in   = PW'(cur_col_ff) + PW'(1);
               end else if (is_newline) begin
                  pcol_in = '0;
                  prow_in = PW'(cur_row_ff) + PW'(1);
               end
            end
         end

         atw_pkg::ST_READ: begin
            cell_in  = rd_ok_ff ? rd_data_ff : '0;
            state_in = atw_pkg::ST_FINISH;
         end

         // zero the cells in use, one per cycle
         atw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            idx_in    = idx_ff + AW'(1);
            if (idx_ff == area_total - AW'(1)) begin
               state_in = atw_pkg::ST_POST;
            end
         end

         // clamp the column, scroll once when the row ran off the screen
         atw_pkg::ST_POST: begin
            cur_col_in = (pcol_ff >= PW'(cols_used)) ? cols_used - CW'(1) : CW'(pcol_ff);
            if (prow_ff >= PW'(rows_used)) begin
               cur_row_in = rows_used - RW'(1);
               idx_in     = '0;
               state_in   = atw_pkg::ST_SCROLL;
            end else begin
               cur_row_in = RW'(prow_ff);
               state_in   = atw_pkg::ST_FINISH;
            end
         end

         // read one row ahead, write it back in the following cycle; bottom row blanked
         atw_pkg::ST_SCROLL: begin
            mem_re       = (idx_ff < area_copy);
            mem_raddr    = idx_ff + AW'(cols_used);
            scr_wr_in    = 1'b1;
            scr_waddr_in = idx_ff;
            scr_copy_in  = (idx_ff < area_copy);
            idx_in       = idx_ff + AW'(1);
            if (idx_ff == area_total - AW'(1)) begin
               state_in = atw_pkg::ST_FINISH;
            end
         end

         atw_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               state_in     = atw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = atw_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         case (csr_index)
            atw_pkg::CSR_COLUMNS: cols_in = csr_wdata;
            atw_pkg::CSR_ROWS:    rows_in = csr_wdata[RW-1:0];
            default: begin
               cols_in = cols_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= atw_pkg::ST_INIT;
         cols_ff      <= atw_pkg::COLUMNS_RESET;
         rows_ff      <= atw_pkg::ROWS_RESET;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         idx_ff       <= '0;
         scr_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         idx_ff       <= idx_in;
         scr_wr_ff    <= scr_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      byte_ff      <= byte_in;
      addr_ff      <= addr_in;
      pcol_ff      <= pcol_in;
      prow_ff      <= prow_in;
      cell_ff      <= cell_in;
      rd_ok_ff     <= rd_ok_in;
      scr_waddr_ff <= scr_waddr_in;
      scr_copy_ff  <= scr_copy_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   // screen memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // every write lands inside the screen
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr < AW'(atw_pkg::CELL_COUNT)))
      else $error("screen write outside the memory");

   // a scroll always leaves the cursor on the last row in use
   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == atw_pkg::ST_SCROLL) |-> (cur_row_ff == rows_used - RW'(1)))
      else $error("scroll without cursor on the last row");

   // after a fed byte the cursor sits inside the screen in use
   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == atw_pkg::ST_FINISH) && ($past(state_ff) == atw_pkg::ST_POST)) |->
      ((cur_col_ff < cols_used) && (cur_row_ff < rows_used)))
      else $error("cursor outside the screen after a byte");

endmodule
`default_nettype wire

// ----- tb/tb_ansi_text_terminal_writer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal_writer_top
// Self-checking bench for the ANSI text terminal writer. Feeds terminal bytes
// and cell reads over the request channel, keeps a shadow screen, cursor and
// escape parser, and checks every response word against it. Covers glyph and
// control bytes, cursor positioning, clear, scrolling, out-of-range register
// values and reads, and screen size changes, under random idle and stalls.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal_writer_top;

   localparam int RUN_LIMIT     = 40_000_000;
   localparam int SETTLE_CYCLES = atw_pkg::CELL_COUNT + 16;
   localparam logic [7:0] ASCII_NUL       = 8'h00;
   localparam logic [7:0] ASCII_DEL       = 8'h7F;
   localparam logic [7:0] BYTE_TOP        = 8'hFF;
   localparam logic [7:0] ASCII_SEMICOLON = 8'h3B;
   localparam logic [7:0] ASCII_COLON     = 8'h3A;
   localparam logic [7:0] ASCII_QUESTION  = 8'h3F;

   typedef struct packed {
      logic [atw_pkg::GLYPH_W-1:0] glyph;
      logic [atw_pkg::COL_W-1:0]   col;
      logic [atw_pkg::ROW_W-1:0]   row;
   } screen_word_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [atw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [atw_pkg::CSR_DATA_W-1:0]  csr_wdata;

   atw_req_if req_bus ();
   atw_rsp_if rsp_bus ();

   ansi_text_terminal_writer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow terminal state
   logic [atw_pkg::GLYPH_W-1:0] shadow_cells [atw_pkg::CELL_COUNT];
   int                          cursor_x, cursor_y;
   atw_pkg::esc_phase_type      parse_phase;
   logic [7:0]                  seq_intro;
   int                          arg_count, arg_first, arg_second;
   logic [atw_pkg::COL_W-1:0]   cfg_columns;
   logic [atw_pkg::ROW_W-1:0]   cfg_rows;

   screen_word_type awaited_words [$];

   int cycle_count    = 0;
   int mismatches     = 0;
   int words_sent     = 0;
   int reads_sent     = 0;
   int sequences_sent = 0;
   int words_checked  = 0;
   int screens_used   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   function automatic int used_columns();
      if (cfg_columns == 0) return 1;
      if (cfg_columns > atw_pkg::MAX_COLUMNS) return atw_pkg::MAX_COLUMNS;
      return int'(cfg_columns);
   endfunction

   function automatic int used_rows();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > atw_pkg::MAX_ROWS) return atw_pkg::MAX_ROWS;
      return int'(cfg_rows);
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= atw_pkg::ASCII_0 && b <= atw_pkg::ASCII_9;
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= atw_pkg::ASCII_UPPER_A && b <= atw_pkg::ASCII_UPPER_Z) ||
             (b >= atw_pkg::ASCII_LOWER_A && b <= atw_pkg::ASCII_LOWER_Z);
   endfunction

   // decimal accumulate, saturating at 16 bits
   function automatic int decimal_step(input int acc, input logic [7:0] digit);
      int v;
      v = acc * 10 + int'(digit - atw_pkg::ASCII_0);
      return (v > 65535) ? 65535 : v;
   endfunction

   // Advance the shadow terminal by one request word; returns the response.
   function automatic screen_word_type apply_terminal_word(
         input logic act, input logic [7:0] code, input logic [atw_pkg::ADDR_W-1:0] addr);
      screen_word_type res;
      int cols, rows, spot;
      res.glyph = '0;
      cols = used_columns();
      rows = used_rows();
      if (act == atw_pkg::ACT_READ) begin
         if (addr < atw_pkg::CELL_COUNT) res.glyph = shadow_cells[addr];
      end else begin
         if (parse_phase != atw_pkg::PH_IDLE) begin
            // inside a sequence nothing is printed
            if (parse_phase == atw_pkg::PH_INTRO) begin
               seq_intro = code;
               parse_phase = atw_pkg::PH_SEQ;
            end
            if (is_letter(code)) begin
               if (seq_intro == atw_pkg::ASCII_LBRACKET) begin
                  if ((code == atw_pkg::ASCII_H || code == atw_pkg::ASCII_F_LOWER) &&
                      arg_count == 2) begin
                     cursor_y = (arg_first - 1) & 8'hFF;
                     cursor_x = (arg_second - 1) & 8'hFF;
                  end else if (code == atw_pkg::ASCII_J && arg_count == 1 &&
                               arg_first == 2) begin
                     for (int i = 0; i < cols * rows; i++) shadow_cells[i] = '0;
                  end
               end
               parse_phase = atw_pkg::PH_IDLE;
            end else if (parse_phase == atw_pkg::PH_SEQ) begin
               if (is_digit(code)) begin
                  if (arg_count < 3) arg_count++;
                  if (arg_count == 1) arg_first = int'(code - atw_pkg::ASCII_0);
                  else if (arg_count == 2) arg_second = int'(code - atw_pkg::ASCII_0);
                  parse_phase = atw_pkg::PH_DIGIT;
               end
            end else if (is_digit(code)) begin
               if (arg_count == 1) arg_first = decimal_step(arg_first, code);
               else if (arg_count == 2) arg_second = decimal_step(arg_second, code);
            end else begin
               parse_phase = atw_pkg::PH_SEQ;
            end
         end else if (code >= atw_pkg::GLYPH_FIRST && code <= atw_pkg::GLYPH_LAST) begin
            spot = cursor_x + cursor_y * cols;
            if (spot < atw_pkg::CELL_COUNT) shadow_cells[spot] = 7'(code - atw_pkg::GLYPH_FIRST);
            cursor_x = (cursor_x + 1) & 8'hFF;
         end else if (code == atw_pkg::ASCII_LF || code == atw_pkg::ASCII_CR) begin
            cursor_y = (cursor_y + 1) & 8'hFF;
            cursor_x = 0;
         end else if (code == atw_pkg::ASCII_ESC) begin
            parse_phase = atw_pkg::PH_INTRO;
            seq_intro = ASCII_NUL;
            arg_count = 0;
         end
         // clamp column, scroll once past the last row
         if (cursor_x >= cols) cursor_x = cols - 1;
         if (cursor_y >= rows) begin
            for (int i = 0; i < cols * (rows - 1); i++) shadow_cells[i] = shadow_cells[i + cols];
            for (int i = cols * (rows - 1); i < cols * rows; i++) shadow_cells[i] = '0;
            cursor_y = rows - 1;
         end
      end
      res.col = cursor_x[atw_pkg::COL_W-1:0];
      res.row = cursor_y[atw_pkg::ROW_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      screen_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("response word with none awaited, cell", rsp_bus.cell_value, -1);
         end else begin
            want = awaited_words.pop_front();
            words_checked++;
            if (rsp_bus.cell_value !== want.glyph)
               report_mismatch("cell_value", rsp_bus.cell_value, want.glyph);
            if (rsp_bus.cursor_column !== want.col)
               report_mismatch("cursor_column", rsp_bus.cursor_column, want.col);
            if (rsp_bus.cursor_row !== want.row)
               report_mismatch("cursor_row", rsp_bus.cursor_row, want.row);
         end
      end
   end

   // response ready: random idle, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout: run exceeded %0d cycles", RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one word, wait for acceptance, then record its expected response.
   task automatic send_word(input logic act, input logic [7:0] code,
                            input logic [atw_pkg::ADDR_W-1:0] addr);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(40, 6) : $urandom_range(5, 1);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.char_byte    <= code;
      req_bus.cell_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      awaited_words.push_back(apply_terminal_word(act, code, addr));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] code);
      send_word(atw_pkg::ACT_FEED, code, 12'($urandom_range(4095)));
   endtask

   task automatic send_read(input logic [atw_pkg::ADDR_W-1:0] addr);
      reads_sent++;
      send_word(atw_pkg::ACT_READ, 8'($urandom_range(255)), addr);
   endtask

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (awaited_words.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // drain, then give a trailing scroll or clear time to finish
   task automatic drain_and_settle();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [atw_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [atw_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == atw_pkg::CSR_COLUMNS) cfg_columns = value[atw_pkg::COL_W-1:0];
      else cfg_rows = value[atw_pkg::ROW_W-1:0];
      @(negedge clock);
   endtask

   task automatic set_screen(input logic [atw_pkg::COL_W-1:0] cols,
                             input logic [atw_pkg::ROW_W-1:0] rows);
      drain_and_settle();
      write_register(atw_pkg::CSR_COLUMNS, cols);
      write_register(atw_pkg::CSR_ROWS, atw_pkg::CSR_DATA_W'(rows));
      screens_used++;
   endtask

   // non-digit, non-letter filler: separators and control bytes
   function automatic logic [7:0] stray_byte();
      case ($urandom_range(5))
         0: return ASCII_COLON;
         1: return ASCII_QUESTION;
         2: return atw_pkg::GLYPH_FIRST;
         3: return atw_pkg::ASCII_CR;
         4: return atw_pkg::ASCII_LF;
         default: return atw_pkg::ASCII_ESC;
      endcase
   endfunction

   // ESC, introducer, up to three decimal arguments, terminating letter
   task automatic send_escape_sequence();
      int n_args, limit, sel;
      logic [7:0] fin;
      string digits;
      sequences_sent++;
      send_byte(atw_pkg::ASCII_ESC);
      if ($urandom_range(15) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(atw_pkg::ASCII_LBRACKET);
      sel = $urandom_range(9);
      if (sel < 6) begin
         fin = $urandom_range(1) ? atw_pkg::ASCII_H : atw_pkg::ASCII_F_LOWER;
         n_args = ($urandom_range(7) == 0) ? $urandom_range(3) : 2;
      end else if (sel < 8) begin
         fin = atw_pkg::ASCII_J;
         n_args = ($urandom_range(5) == 0) ? $urandom_range(3) : 1;
      end else begin
         fin = $urandom_range(1) ? 8'(atw_pkg::ASCII_UPPER_A + $urandom_range(25))
                                 : 8'(atw_pkg::ASCII_LOWER_A + $urandom_range(25));
         n_args = $urandom_range(3);
      end
      if ($urandom_range(9) == 0) send_byte(stray_byte());
      for (int k = 0; k < n_args; k++) begin
         if (k > 0) send_byte(($urandom_range(7) == 0) ? stray_byte() : ASCII_SEMICOLON);
         limit = (k == 0) ? used_rows() : used_columns();
         sel = $urandom_range(19);
         if (sel == 0) begin
            // long digit run, can saturate
            digits = "";
            repeat ($urandom_range(7, 5)) digits = $sformatf("%s%0d", digits, $urandom_range(9));
         end else if (sel == 1) begin
            digits = $sformatf("%0d", $urandom_range(260, 250));
         end else if (sel == 2) begin
            digits = "0";
         end else if (fin == atw_pkg::ASCII_J && k == 0 && sel < 18) begin
            digits = "2";
         end else begin
            digits = $sformatf("%0d", $urandom_range(limit + 2, 1));
         end
         if ($urandom_range(9) == 0) digits = {"0", digits};
         for (int j = 0; j < digits.len(); j++) send_byte(digits[j]);
      end
      send_byte(fin);
   endtask

   // ---- directed tests ----

   task automatic test_reset_readout();
      send_read('0);
      send_read(12'(atw_pkg::CELL_COUNT - 1));
      send_read(12'hFFF);
   endtask

   task automatic test_glyph_extremes();
      send_byte(atw_pkg::GLYPH_FIRST);
      send_byte(atw_pkg::GLYPH_LAST);
      send_byte(ASCII_DEL);
      send_byte(BYTE_TOP);
      send_byte(ASCII_NUL);
   endtask

   // ESC[0;99f: row wraps to 255 and scrolls, column clamps; then print at the edge
   task automatic test_cursor_escape();
      send_byte(atw_pkg::ASCII_ESC);
      send_byte(atw_pkg::ASCII_LBRACKET);
      send_byte(atw_pkg::ASCII_0);
      send_byte(ASCII_SEMICOLON);
      send_byte(atw_pkg::ASCII_9);
      send_byte(atw_pkg::ASCII_9);
      send_byte(atw_pkg::ASCII_F_LOWER);
      send_byte(atw_pkg::ASCII_UPPER_A);
      send_byte(atw_pkg::ASCII_UPPER_Z);
   endtask

   task automatic test_line_feed_scroll();
      send_byte(atw_pkg::ASCII_LF);
      send_read(12'(atw_pkg::CELL_COUNT - 1 - atw_pkg::MAX_COLUMNS));
      send_byte(atw_pkg::ASCII_CR);
   endtask

   task automatic test_clear_screen();
      send_byte(atw_pkg::ASCII_ESC);
      send_byte(atw_pkg::ASCII_LBRACKET);
      send_byte(8'(atw_pkg::ASCII_0 + 2));
      send_byte(atw_pkg::ASCII_J);
      send_read(12'(atw_pkg::CELL_COUNT - 1 - 2 * atw_pkg::MAX_COLUMNS));
   endtask

   // ---- random traffic on one screen size ----

   task automatic test_random_phase(input logic [atw_pkg::COL_W-1:0] cols,
                                    input logic [atw_pkg::ROW_W-1:0] rows,
                                    input int s_pct, input int r_pct, input int n_words);
      int done, mark, sel, cells;
      bit paused;
      set_screen(cols, rows);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      done = 0;
      paused = 0;
      while (done < n_words) begin
         mark = words_sent;
         sel = $urandom_range(99);
         if (sel < 14) begin
            cells = used_columns() * used_rows();
            send_read(12'($urandom_range(cells - 1)));
         end else if (sel < 18) begin
            send_read(12'($urandom_range(4095)));
         end else if (sel < 54) begin
            send_byte(8'($urandom_range(126, 32)));
         end else if (sel < 62) begin
            send_byte($urandom_range(1) ? atw_pkg::ASCII_CR : atw_pkg::ASCII_LF);
         end else if (sel < 84) begin
            send_escape_sequence();
         end else if (sel < 89) begin
            // broken sequence: ESC and arbitrary bytes
            send_byte(atw_pkg::ASCII_ESC);
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end else begin
            send_byte(8'($urandom_range(255)));
         end
         done += words_sent - mark;
         // sender stops once per phase until every response is back
         if (!paused && done >= n_words / 2) begin
            pause_until_drained();
            paused = 1;
         end
      end
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 300;
      repeat (40) begin
         if ($urandom_range(3) == 0) send_read(12'($urandom_range(atw_pkg::CELL_COUNT - 1)));
         else send_byte(8'($urandom_range(126, 32)));
      end
      pause_until_drained();
   endtask

   initial begin : stimulus
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = atw_pkg::CSR_COLUMNS;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.action       = atw_pkg::ACT_FEED;
      req_bus.char_byte    = ASCII_NUL;
      req_bus.cell_address = '0;
      rsp_bus.ready        = 1'b0;

      for (int i = 0; i < atw_pkg::CELL_COUNT; i++) shadow_cells[i] = '0;
      cursor_x    = 0;
      cursor_y    = 0;
      parse_phase = atw_pkg::PH_IDLE;
      seq_intro   = ASCII_NUL;
      arg_count   = 0;
      arg_first   = 0;
      arg_second  = 0;
      cfg_columns = atw_pkg::COLUMNS_RESET;
      cfg_rows    = atw_pkg::ROWS_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 75;
      test_reset_readout();
      test_glyph_extremes();
      test_cursor_escape();
      test_line_feed_scroll();
      test_clear_screen();

      // sender idles a quarter, receiver three quarters
      test_random_phase(7'd1,   5'd1,  25, 75, 150);
      test_random_phase(7'd0,   5'd0,  25, 75, 60);
      test_random_phase(7'd16,  5'd4,  25, 75, 300);
      // roles swapped
      test_random_phase(7'd7,   5'd3,  75, 25, 300);
      test_random_phase(7'd127, 5'd31, 75, 25, 50);
      test_random_phase(7'd5,   5'd2,  75, 25, 200);
      // no idling
      test_random_phase(7'd12,  5'd5,  0,  0,  250);
      test_backpressure();
      test_random_phase(7'd80,  5'd30, 0,  0,  40);
      test_random_phase(7'd3,   5'd6,  0,  0,  150);

      drain_and_settle();
      if (awaited_words.size() != 0)
         report_mismatch("responses never seen", 0, awaited_words.size());

      $display("Covered %0d words (%0d cell reads, %0d escape sequences) over %0d screen sizes.",
               words_sent, reads_sent, sequences_sent, screens_used);
      $display("Checked %0d response words, %0d mismatches.", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/atw_pkg.sv
sv/atw_req_if.sv
sv/atw_rsp_if.sv
sv/atw_esc.sv
sv/ansi_text_terminal_writer_top.sv
tb/tb_ansi_text_terminal_writer_top.sv
